// File: hdl/sorted_table_binary_search_defines.svh
// assertion macros for the sorted table binary search block
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, off while reset is low
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs same-cycle check failed");
// next-cycle implication, off while reset is low
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs next-cycle check failed");
`else
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
// no dependencies; imported by the front, back and top level
package stbs_pkg;

    // fixed field widths of the item ports
    localparam int INDEX_W = 4;

    // default sizing, handed down from the top level
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // queue depths (powers of two)
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // command kinds passed from front to back
    localparam int CMD_KIND_W = 2;

    typedef enum logic [CMD_KIND_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_MISS   = 2'd2
    } cmd_kind_t;

    // search engine states
    typedef enum logic {
        ENG_IDLE  = 1'b0,
        ENG_PROBE = 1'b1
    } eng_state_t;

endpackage

// File: hdl/stbs_ram.sv
// generic single-port ram with registered read data
// no dependencies; holds the sorted table
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle: write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/stbs_fifo.sv
// small synchronous fifo with first-word fall-through output
// no dependencies; used for the command queue and the result queue
module stbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         din,
    output logic                     full,
    input  logic                     pop,
    output logic [WIDTH-1:0]         dout,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = PTR_W + 1;

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    // handshake qualification
    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = data_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

// File: hdl/stbs_front.sv
// front end: accepts items and turns them into engine commands
// depends on stbs_pkg; feeds the command fifo
module stbs_front #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF,
    parameter int CMD_W       = stbs_pkg::CMD_KIND_W + 2 * $clog2(TABLE_DEPTH) + VALUE_WIDTH
) (
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [stbs_pkg::INDEX_W-1:0] entry_index,
    input  logic [VALUE_WIDTH-1:0]      entry_value,
    input  logic [stbs_pkg::INDEX_W-1:0] range_first,
    input  logic [stbs_pkg::INDEX_W-1:0] range_last,
    input  logic [VALUE_WIDTH-1:0]      search_key,
    output logic                        cmd_push,
    output logic [CMD_W-1:0]            cmd_data,
    input  logic                        cmd_full
);

    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam logic [CMP_W-1:0] LAST_IDX = CMP_W'(TABLE_DEPTH - 1);

    logic             accept;
    logic             write_ok;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] last_ext;
    logic [CMP_W-1:0] last_clip;
    logic             range_empty;
    cmd_kind_t        kind;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [VALUE_WIDTH-1:0] value;

    assign accept = push && !cmd_full;
    assign full   = cmd_full;

    // range clipping and emptiness
    assign first_ext   = CMP_W'(range_first);
    assign last_ext    = CMP_W'(range_last);
    assign last_clip   = (last_ext > LAST_IDX) ? LAST_IDX : last_ext;
    assign range_empty = (first_ext > last_clip);
    assign write_ok    = (CMP_W'(entry_index) <= LAST_IDX);

    // classify the item
    always_comb
    begin
        if (opcode == OP_WRITE)
        begin
            kind    = CMD_WRITE;
            lo_addr = ADDR_W'(CMP_W'(entry_index));
            hi_addr = ADDR_W'(CMP_W'(entry_index));
            value   = entry_value;
        end
        else
        begin
            kind    = range_empty ? CMD_MISS : CMD_SEARCH;
            lo_addr = ADDR_W'(first_ext);
            hi_addr = ADDR_W'(last_clip);
            value   = search_key;
        end
    end

    // writes beyond the table are taken and dropped
    assign cmd_push = accept && !((opcode == OP_WRITE) && !write_ok);
    assign cmd_data = {kind, lo_addr, hi_addr, value};

endmodule

// File: hdl/stbs_back.sv
// back end: search engine over the table ram, one probe per cycle
// depends on stbs_pkg, stbs_ram and the assertion header
`include "sorted_table_binary_search_defines.svh"

module stbs_back #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF,
    parameter int RES_DEPTH   = stbs_pkg::RES_QUEUE_DEPTH,
    parameter int CMD_W       = stbs_pkg::CMD_KIND_W + 2 * $clog2(TABLE_DEPTH) + VALUE_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_empty,
    input  logic [CMD_W-1:0]           cmd_data,
    output logic                       cmd_pop,
    input  logic [$clog2(RES_DEPTH):0] res_level,
    output logic                       res_push,
    output logic                       res_found
);

    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LVL_W  = $clog2(RES_DEPTH) + 1;

    eng_state_t state_reg;
    eng_state_t state_next;

    logic [ADDR_W-1:0]      lo_reg;
    logic [ADDR_W-1:0]      lo_next;
    logic [ADDR_W-1:0]      hi_reg;
    logic [ADDR_W-1:0]      hi_next;
    logic [ADDR_W-1:0]      mid_reg;
    logic [ADDR_W-1:0]      mid_next;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] key_next;

    cmd_kind_t              c_kind;
    logic [ADDR_W-1:0]      c_lo;
    logic [ADDR_W-1:0]      c_hi;
    logic [VALUE_WIDTH-1:0] c_value;
    logic [ADDR_W-1:0]      c_mid;

    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   ram_en;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;

    logic                   probing;
    logic                   key_eq;
    logic                   key_less;
    logic                   probe_end;
    logic                   probe_done;
    logic [ADDR_W-1:0]      nlo;
    logic [ADDR_W-1:0]      nhi;
    logic [ADDR_W-1:0]      nmid;
    logic                   engine_free;
    logic                   res_room;
    logic                   pop_write;
    logic                   pop_search;
    logic                   pop_miss;

    // command fields
    assign c_kind  = cmd_kind_t'(cmd_data[CMD_W-1 -: CMD_KIND_W]);
    assign c_lo    = cmd_data[VALUE_WIDTH + 2*ADDR_W - 1 -: ADDR_W];
    assign c_hi    = cmd_data[VALUE_WIDTH + ADDR_W - 1 -: ADDR_W];
    assign c_value = cmd_data[VALUE_WIDTH-1:0];
    assign c_mid   = c_lo + ((c_hi - c_lo) >> 1);

    // probe compare against the entry read last cycle
    assign probing    = (state_reg == ENG_PROBE);
    assign key_eq     = (ram_rdata == key_reg);
    assign key_less   = ($signed(key_reg) < $signed(ram_rdata));
    assign probe_end  = key_eq || (key_less ? (mid_reg == lo_reg) : (mid_reg == hi_reg));
    assign probe_done = probing && probe_end;

    // narrowed range for the next probe
    assign nlo  = key_less ? lo_reg : mid_reg + 1'b1;
    assign nhi  = key_less ? mid_reg - 1'b1 : hi_reg;
    assign nmid = nlo + ((nhi - nlo) >> 1);

    // the engine can take a command when idle or on its last compare
    assign engine_free = !probing || probe_end;
    assign res_room    = ((LVL_W + 1)'(res_level) + (LVL_W + 1)'(probe_done))
                         < (LVL_W + 1)'(RES_DEPTH);

    // command pop decision
    always_comb
    begin
        cmd_pop = 1'b0;
        if (!cmd_empty && engine_free)
        begin
            unique case (c_kind)
                CMD_WRITE:  cmd_pop = 1'b1;
                CMD_SEARCH: cmd_pop = res_room;
                CMD_MISS:   cmd_pop = !probing && res_room;
                default:    cmd_pop = 1'b1;
            endcase
        end
    end

    assign pop_write  = cmd_pop && (c_kind == CMD_WRITE);
    assign pop_search = cmd_pop && (c_kind == CMD_SEARCH);
    assign pop_miss   = cmd_pop && (c_kind == CMD_MISS);

    // next state
    always_comb
    begin
        unique case (state_reg)
            ENG_IDLE:  state_next = pop_search ? ENG_PROBE : ENG_IDLE;
            ENG_PROBE: state_next = (!probe_end || pop_search) ? ENG_PROBE : ENG_IDLE;
            default:   state_next = ENG_IDLE;
        endcase
    end

    // outputs: table port and result push
    always_comb
    begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = c_lo;
        if (pop_write)
        begin
            ram_en = 1'b1;
            ram_we = 1'b1;
        end
        else if (pop_search)
        begin
            ram_en   = 1'b1;
            ram_addr = c_mid;
        end
        else if (probing && !probe_end)
        begin
            ram_en   = 1'b1;
            ram_addr = nmid;
        end
        res_push  = probe_done || pop_miss;
        res_found = probe_done && key_eq;
    end

    // search registers
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        key_next = key_reg;
        if (pop_search)
        begin
            lo_next  = c_lo;
            hi_next  = c_hi;
            mid_next = c_mid;
            key_next = c_value;
        end
        else if (probing && !probe_end)
        begin
            lo_next  = nlo;
            hi_next  = nhi;
            mid_next = nmid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    // sorted table storage
    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (c_value),
        .rdata (ram_rdata)
    );

    // checks
    `STBS_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, (res_level < LVL_W'(RES_DEPTH)))
    `STBS_ASSERT_IMP(a_probe_in_range, clk, rst_n, probing, (lo_reg <= mid_reg) && (mid_reg <= hi_reg))
    `STBS_ASSERT_IMP(a_write_port_free, clk, rst_n, pop_write, !(probing && !probe_end))
    `STBS_ASSERT_NXT(a_search_starts, clk, rst_n, pop_search, (state_reg == ENG_PROBE))

endmodule

// File: hdl/sorted_table_binary_search.sv
// top level of the sorted table binary search block
// depends on stbs_pkg, stbs_front, stbs_fifo and stbs_back
//
// channel   direction  handshake            payload
// input     in         push / full          opcode, entry_index, entry_value,
//                                           range_first, range_last, search_key
// result    out        empty / pop          found
//
// a write item takes a single table access; an empty or reversed search
// range gives found = 0 without touching the table.
// a search makes at most log2(TABLE_DEPTH)+1 probes (5 at depth 16), one probe
// per cycle through the single table port; the last compare overlaps a
// following write or search, while an empty range waits until the engine is idle.
// a two-entry command queue lets items be taken while the engine works, and a
// two-entry result queue lets results wait for pop.
// reset clears queues and engine state; table contents are undefined until written.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         opcode,
    input  logic [stbs_pkg::INDEX_W-1:0] entry_index,
    input  logic [VALUE_WIDTH-1:0]       entry_value,
    input  logic [stbs_pkg::INDEX_W-1:0] range_first,
    input  logic [stbs_pkg::INDEX_W-1:0] range_last,
    input  logic [VALUE_WIDTH-1:0]       search_key,
    output logic                         empty,
    input  logic                         pop,
    output logic                         found
);

    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CMD_W  = CMD_KIND_W + 2 * ADDR_W + VALUE_WIDTH;

    logic                               cmd_push;
    logic [CMD_W-1:0]                   cmd_in;
    logic                               cmd_full;
    logic                               cmd_pop;
    logic [CMD_W-1:0]                   cmd_out;
    logic                               cmd_empty;
    logic                               res_push;
    logic                               res_found;
    logic [$clog2(RES_QUEUE_DEPTH):0]   res_level;

    // item intake and classification
    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CMD_W       (CMD_W)
    ) u_front (
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_first (range_first),
        .range_last  (range_last),
        .search_key  (search_key),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .cmd_full    (cmd_full)
    );

    // command queue between front and engine
    stbs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty),
        .level ()
    );

    // search engine and table
    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .RES_DEPTH   (RES_QUEUE_DEPTH),
        .CMD_W       (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_level (res_level),
        .res_push  (res_push),
        .res_found (res_found)
    );

    // result queue toward the consumer
    stbs_fifo #(
        .WIDTH (1),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_found),
        .full  (),
        .pop   (pop),
        .dout  (found),
        .empty (empty),
        .level (res_level)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_table_binary_search: directed and random write/search items
// a small scoreboard class predicts the found bit; depends on stbs_pkg and the block's rtl
module tb;

    localparam int DEPTH       = 16;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = stbs_pkg::INDEX_W;
    localparam int RANDOM_ITEMS = 425;
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 250;
    localparam int HOLD_AT     = 60;
    localparam int DRAIN_AT    = 200;
    localparam int END_WAIT    = 20;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct {
        logic                          opcode;
        logic [stbs_pkg::INDEX_W-1:0]  entry_index;
        logic signed [VALUE_W-1:0]     entry_value;
        logic [stbs_pkg::INDEX_W-1:0]  range_first;
        logic [stbs_pkg::INDEX_W-1:0]  range_last;
        logic signed [VALUE_W-1:0]     search_key;
    } search_item_t;

    // mirror of the table and the queue of found bits still owed by the block
    class found_scoreboard;
        logic signed [VALUE_W-1:0] entries [DEPTH];
        bit expected_found [$];
        int writes;
        int searches;
        int hits;
        int errors;

        // halving search over an inclusive range, last index clipped to the table
        function bit search_range(int first, int last, logic signed [VALUE_W-1:0] key);
            int lo;
            int hi;
            int mid;
            lo = first;
            hi = (last > DEPTH - 1) ? DEPTH - 1 : last;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] == key)
                    return 1'b1;
                if (key < entries[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return 1'b0;
        endfunction

        function void note_item(search_item_t it);
            bit hit;
            if (it.opcode == stbs_pkg::OP_WRITE) begin
                if (it.entry_index < DEPTH)
                    entries[it.entry_index] = it.entry_value;
                writes++;
            end
            else begin
                hit = search_range(it.range_first, it.range_last, it.search_key);
                expected_found.push_back(hit);
                searches++;
                hits += hit;
            end
        endfunction

        function void check_found(logic actual);
            bit want;
            if (expected_found.size() == 0) begin
                $error("found: result with no search pending, actual %0b", actual);
                errors++;
            end
            else begin
                want = expected_found.pop_front();
                if (actual !== want) begin
                    $error("found: expected %0b, actual %0b", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_found.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic                          opcode = stbs_pkg::OP_WRITE;
    logic [stbs_pkg::INDEX_W-1:0]  entry_index = '0;
    logic [VALUE_W-1:0]            entry_value = '0;
    logic [stbs_pkg::INDEX_W-1:0]  range_first = '0;
    logic [stbs_pkg::INDEX_W-1:0]  range_last = '0;
    logic [VALUE_W-1:0]            search_key = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic                          found;

    found_scoreboard sb = new();
    int sent = 0;
    int popped = 0;
    int idle_cycles = 0;
    int fresh [DEPTH];

    sorted_table_binary_search #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_WIDTH (VALUE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_first (range_first),
        .range_last  (range_last),
        .search_key  (search_key),
        .empty       (empty),
        .pop         (pop),
        .found       (found)
    );

    always #1 clk = ~clk;

    // item builders; unused fields carry random noise
    function automatic search_item_t write_of(int idx, logic signed [VALUE_W-1:0] val);
        search_item_t it;
        it.opcode      = stbs_pkg::OP_WRITE;
        it.entry_index = IDX_W'(idx);
        it.entry_value = val;
        it.range_first = IDX_W'($urandom_range(0, DEPTH - 1));
        it.range_last  = IDX_W'($urandom_range(0, DEPTH - 1));
        it.search_key  = $urandom;
        return it;
    endfunction

    function automatic search_item_t search_of(int first, int last,
                                               logic signed [VALUE_W-1:0] key);
        search_item_t it;
        it.opcode      = stbs_pkg::OP_SEARCH;
        it.entry_index = IDX_W'($urandom_range(0, DEPTH - 1));
        it.entry_value = $urandom;
        it.range_first = IDX_W'(first);
        it.range_last  = IDX_W'(last);
        it.search_key  = key;
        return it;
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(search_item_t it);
        int gap;
        gap = (sent >= 250 && sent < 330) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        opcode      <= it.opcode;
        entry_index <= it.entry_index;
        entry_value <= it.entry_value;
        range_first <= it.range_first;
        range_last  <= it.range_last;
        search_key  <= it.search_key;
        do @(posedge clk); while (full);
        sb.note_item(it);
        sent++;
    endtask

    // refill the whole table in ascending order with values of a random flavor
    task automatic rebuild_table();
        int mode;
        int base;
        int tmp;
        int j;
        mode = $urandom_range(0, 2);
        base = $urandom;
        for (int i = 0; i < DEPTH; i++) begin
            case (mode)
                0: fresh[i] = $urandom;
                1: fresh[i] = base + $urandom_range(0, 40);
                default: fresh[i] = ($urandom_range(0, 3) == 0) ?
                                    (($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN) :
                                    int'($urandom);
            endcase
        end
        // insertion sort, signed order
        for (int i = 1; i < DEPTH; i++) begin
            tmp = fresh[i];
            j = i - 1;
            while (j >= 0 && fresh[j] > tmp) begin
                fresh[j + 1] = fresh[j];
                j--;
            end
            fresh[j + 1] = tmp;
        end
        for (int i = 0; i < DEPTH; i++)
            send_item(write_of(i, fresh[i]));
    endtask

    // search with mostly ordered ranges and keys taken from the table, next to an entry or at random
    task automatic random_search();
        int first;
        int last;
        int tmp;
        int pick;
        logic signed [VALUE_W-1:0] key;
        first = $urandom_range(0, DEPTH - 1);
        last  = $urandom_range(0, DEPTH - 1);
        if (first > last && $urandom_range(0, 99) < 85) begin
            tmp = first;
            first = last;
            last = tmp;
        end
        pick = $urandom_range(0, 9);
        key = sb.entries[$urandom_range(0, DEPTH - 1)];
        if (pick >= 5 && pick < 7)
            key = ($urandom_range(0, 1) == 1) ? key + 1 : key - 1;
        else if (pick >= 7)
            key = $urandom;
        send_item(search_of(first, last, key));
    endtask

    // directed values, ascending with both extremes at the ends
    int dir_vals [DEPTH] = '{32'sh80000000, -1000000000, -70000, -300, -2, -1, 0, 1,
                             5, 40, 999, 65536, 123456789, 2000000000, 2147483646,
                             32'sh7fffffff};

    // stimulus and end of run
    initial
    begin
        int since_rebuild;
        bit drained;
        since_rebuild = 0;
        drained = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reversed range before any write touches nothing
        send_item(search_of(9, 3, 0));
        for (int i = 0; i < DEPTH; i++)
            send_item(write_of(i, dir_vals[i]));
        send_item(search_of(0, 15, VAL_MIN));
        send_item(search_of(0, 15, VAL_MAX));
        send_item(search_of(15, 15, VAL_MAX));
        send_item(search_of(0, 0, VAL_MIN));
        send_item(search_of(0, 15, 4));
        send_item(search_of(1, 14, VAL_MIN));
        send_item(search_of(15, 0, -1));
        send_item(search_of(4, 12, -1));

        // random part: table refills, searches and stray writes that break the order
        while (sent < RANDOM_ITEMS + 25) begin
            if (!drained && sent >= DRAIN_AT) begin
                push <= 1'b0;
                @(posedge clk);
                while (sb.pending() > 0) @(posedge clk);
                drained = 1'b1;
            end
            if (since_rebuild >= 60) begin
                rebuild_table();
                since_rebuild = 0;
            end
            else if ($urandom_range(0, 9) == 0) begin
                send_item(write_of($urandom_range(0, DEPTH - 1), $urandom));
                since_rebuild++;
            end
            else begin
                random_search();
                since_rebuild++;
            end
        end
        push <= 1'b0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("found: %0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("covered %0d items: %0d table writes and %0d searches, %0d of them hits",
                 sent, sb.writes, sb.searches, sb.hits);
        $display("included a %0d-cycle result hold-off and a full drain pause", LONG_HOLD);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random pop gaps, one long hold-off, one stretch with no gaps
    initial
    begin : result_drain
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (popped == HOLD_AT)
                gap = LONG_HOLD;
            else if (popped >= 150 && popped < 230)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            sb.check_found(found);
            popped++;
        end
    end

    // watchdog on cycles without any accepted item or result
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/stbs_fifo.sv
hdl/stbs_front.sv
hdl/stbs_back.sv
hdl/sorted_table_binary_search.sv
sim/tb.sv
